### hdl/rdce_pkg.sv
package rdce_pkg;

  localparam logic [7:0] BLANK_COLOR = 8'd79;

  // Configuration register indexes.
  localparam logic CFG_WIDTH_IDX  = 1'b0;
  localparam logic CFG_HEIGHT_IDX = 1'b1;

  // Queue depths between the parts.
  localparam int CMD_QUEUE_DEPTH = 4;
  localparam int RES_QUEUE_DEPTH = 2;

  typedef logic [8:0] coord_t;
  typedef logic [7:0] color_t;

  typedef enum logic [2:0] {
    OP_CLEAR   = 3'd0,
    OP_PIXEL   = 3'd1,
    OP_VLINE   = 3'd2,
    OP_HLINE   = 3'd3,
    OP_RECT    = 3'd4,
    OP_RECOLOR = 3'd5,
    OP_READ    = 3'd6,
    OP_NOP     = 3'd7
  } op_t;

  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_SIZE  = 2'd1,
    ST_RANGE = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    CMD_NONE,
    CMD_FILL,
    CMD_RECOLOR,
    CMD_READ
  } cmd_kind_t;

  // Classified command: all coordinates are 0-based and already checked.
  typedef struct packed {
    cmd_kind_t kind;
    status_t   status;
    coord_t    px;
    coord_t    py;
    coord_t    x0;
    coord_t    y0;
    coord_t    x1;
    coord_t    y1;
    color_t    color;
  } cmd_t;

  typedef struct packed {
    status_t status;
    color_t  pixel;
  } result_t;

  typedef enum logic [3:0] {
    BK_INIT,
    BK_IDLE,
    BK_SETUP,
    BK_FILL,
    BK_SEED_RD,
    BK_SEED_WAIT,
    BK_SCAN,
    BK_DRAIN,
    BK_READ_RD,
    BK_READ_WAIT,
    BK_RESULT
  } back_state_t;

endpackage

### hdl/raster_draw_command_engine.sv
// Raster drawing engine over a MAX_WIDTH x MAX_HEIGHT frame of 8-bit colors.
// Input channel: push a command word (operation, corners, color) while full
// is low; it is accepted on that edge. Result channel: while empty is low the
// oldest result word (status, pixel_value) sits on out_*; pop takes it.
// Every command yields exactly one result word, in command order.
// Config: cfg_wr_en with cfg_index 0 (width) or 1 (height) writes the size in
// use; write it only while no command is outstanding.
// The back end draws one command at a time, one pixel a cycle, and takes the
// next command only once it has pushed the result of the last one.
// A front stage checks and classifies each word and pushes it into a
// 4-deep command queue, so up to four commands are taken while the back end
// draws. At reset the back end sweeps the whole store to blank ('O'), one
// pixel a cycle, holding full high meanwhile; config writes are still taken.
// When the receiver stalls, results collect in a 2-deep result queue, then
// the back end holds, then the command queue fills.
module raster_draw_command_engine #(
  parameter int MAX_WIDTH  = 256,
  parameter int MAX_HEIGHT = 256
) (
  input  logic       clk,
  input  logic       rst_n,
  // configuration port
  input  logic       cfg_wr_en,
  input  logic       cfg_index,
  input  logic [8:0] cfg_wdata,
  // command channel
  input  logic       in_push,
  output logic       in_full,
  input  logic [2:0] in_operation,
  input  logic [8:0] in_x_first,
  input  logic [8:0] in_y_first,
  input  logic [8:0] in_x_last,
  input  logic [8:0] in_y_last,
  input  logic [7:0] in_paint_color,
  // result channel
  output logic       out_empty,
  input  logic       out_pop,
  output logic [1:0] out_status,
  output logic [7:0] out_pixel_value
);

  rdce_pkg::cmd_t    front_cmd;
  rdce_pkg::cmd_t    cmd_head;
  rdce_pkg::result_t back_res;
  rdce_pkg::result_t res_head;
  logic              cmd_push;
  logic              cmd_full;
  logic              cmd_empty;
  logic              cmd_pop;
  logic              res_push;
  logic              res_full;
  logic              back_busy;

  // Front: take the word, clamp sizes, range-check and classify.
  rdce_front #(
    .MAX_WIDTH (MAX_WIDTH),
    .MAX_HEIGHT(MAX_HEIGHT)
  ) u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata),
    .in_push       (in_push),
    .in_full       (in_full),
    .in_operation  (in_operation),
    .in_x_first    (in_x_first),
    .in_y_first    (in_y_first),
    .in_x_last     (in_x_last),
    .in_y_last     (in_y_last),
    .in_paint_color(in_paint_color),
    .back_busy     (back_busy),
    .cmd_full      (cmd_full),
    .cmd_push      (cmd_push),
    .cmd           (front_cmd)
  );

  // Command queue decouples classification from drawing.
  rdce_fifo #(
    .WIDTH($bits(rdce_pkg::cmd_t)),
    .DEPTH(rdce_pkg::CMD_QUEUE_DEPTH)
  ) u_cmd_q (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (cmd_push),
    .wr_data(front_cmd),
    .full   (cmd_full),
    .pop    (cmd_pop),
    .rd_data(cmd_head),
    .empty  (cmd_empty)
  );

  // Back: owns the frame store and walks boxes one pixel a cycle.
  rdce_back #(
    .MAX_WIDTH (MAX_WIDTH),
    .MAX_HEIGHT(MAX_HEIGHT)
  ) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd_empty(cmd_empty),
    .cmd_head (cmd_head),
    .cmd_pop  (cmd_pop),
    .res_full (res_full),
    .res_push (res_push),
    .res      (back_res),
    .busy_init(back_busy)
  );

  // Result queue: hold finished words while the receiver stalls.
  rdce_fifo #(
    .WIDTH($bits(rdce_pkg::result_t)),
    .DEPTH(rdce_pkg::RES_QUEUE_DEPTH)
  ) u_res_q (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (res_push),
    .wr_data(back_res),
    .full   (res_full),
    .pop    (out_pop),
    .rd_data(res_head),
    .empty  (out_empty)
  );

  assign out_status      = res_head.status;
  assign out_pixel_value = res_head.pixel;

endmodule

### hdl/rdce_fifo.sv
module rdce_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] wr_data,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rd_data,
  output logic             empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PW-1:0]    wp_r;
  logic [PW-1:0]    rp_r;
  logic [PW:0]      cnt_r;
  logic             do_push;
  logic             do_pop;

  assign full    = (cnt_r == (PW+1)'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rd_data = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wp_r] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (do_push) begin
        wp_r <= (wp_r == PW'(DEPTH - 1)) ? '0 : wp_r + 1'b1;
      end
      if (do_pop) begin
        rp_r <= (rp_r == PW'(DEPTH - 1)) ? '0 : rp_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

endmodule

### hdl/rdce_front.sv
module rdce_front #(
  parameter int MAX_WIDTH  = 256,
  parameter int MAX_HEIGHT = 256
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          cfg_wr_en,
  input  logic          cfg_index,
  input  logic [8:0]    cfg_wdata,
  input  logic          in_push,
  output logic          in_full,
  input  logic [2:0]    in_operation,
  input  logic [8:0]    in_x_first,
  input  logic [8:0]    in_y_first,
  input  logic [8:0]    in_x_last,
  input  logic [8:0]    in_y_last,
  input  logic [7:0]    in_paint_color,
  input  logic          back_busy,
  input  logic          cmd_full,
  output logic          cmd_push,
  output rdce_pkg::cmd_t cmd
);

  logic [8:0] width_r;
  logic [8:0] height_r;
  logic [8:0] eff_w;
  logic [8:0] eff_h;
  logic       xa_ok, ya_ok, xb_ok, yb_ok;
  logic [8:0] xa_m1, ya_m1, xb_m1, yb_m1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= 9'd256;
      height_r <= 9'd256;
    end else if (cfg_wr_en) begin
      if (cfg_index == rdce_pkg::CFG_WIDTH_IDX) begin
        width_r <= cfg_wdata;
      end else begin
        height_r <= cfg_wdata;
      end
    end
  end

  // Clamp the sizes in use to 1..MAX.
  always_comb begin
    if (width_r == 9'd0) begin
      eff_w = 9'd1;
    end else if (32'(width_r) > MAX_WIDTH) begin
      eff_w = 9'(MAX_WIDTH);
    end else begin
      eff_w = width_r;
    end
    if (height_r == 9'd0) begin
      eff_h = 9'd1;
    end else if (32'(height_r) > MAX_HEIGHT) begin
      eff_h = 9'(MAX_HEIGHT);
    end else begin
      eff_h = height_r;
    end
  end

  assign xa_ok = (in_x_first != 9'd0) && (in_x_first <= eff_w);
  assign xb_ok = (in_x_last  != 9'd0) && (in_x_last  <= eff_w);
  assign ya_ok = (in_y_first != 9'd0) && (in_y_first <= eff_h);
  assign yb_ok = (in_y_last  != 9'd0) && (in_y_last  <= eff_h);

  assign xa_m1 = in_x_first - 9'd1;
  assign ya_m1 = in_y_first - 9'd1;
  assign xb_m1 = in_x_last  - 9'd1;
  assign yb_m1 = in_y_last  - 9'd1;

  assign in_full  = cmd_full || back_busy;
  assign cmd_push = in_push && !in_full;

  always_comb begin
    cmd        = '0;
    cmd.kind   = rdce_pkg::CMD_NONE;
    cmd.status = rdce_pkg::ST_DONE;
    cmd.color  = in_paint_color;
    case (rdce_pkg::op_t'(in_operation))
      rdce_pkg::OP_CLEAR: begin
        cmd.kind  = rdce_pkg::CMD_FILL;
        cmd.x1    = eff_w - 9'd1;
        cmd.y1    = eff_h - 9'd1;
        cmd.color = rdce_pkg::BLANK_COLOR;
      end
      rdce_pkg::OP_PIXEL: begin
        if (!xa_ok || !ya_ok) begin
          cmd.status = rdce_pkg::ST_RANGE;
        end else begin
          cmd.kind = rdce_pkg::CMD_FILL;
          cmd.x0   = xa_m1;
          cmd.x1   = xa_m1;
          cmd.y0   = ya_m1;
          cmd.y1   = ya_m1;
        end
      end
      rdce_pkg::OP_VLINE: begin
        if (!xa_ok || !ya_ok || !yb_ok) begin
          cmd.status = rdce_pkg::ST_RANGE;
        end else if (in_y_first <= in_y_last) begin
          cmd.kind = rdce_pkg::CMD_FILL;
          cmd.x0   = xa_m1;
          cmd.x1   = xa_m1;
          cmd.y0   = ya_m1;
          cmd.y1   = yb_m1;
        end
      end
      rdce_pkg::OP_HLINE: begin
        if (!xa_ok || !xb_ok || !ya_ok) begin
          cmd.status = rdce_pkg::ST_RANGE;
        end else if (in_x_first <= in_x_last) begin
          cmd.kind = rdce_pkg::CMD_FILL;
          cmd.x0   = xa_m1;
          cmd.x1   = xb_m1;
          cmd.y0   = ya_m1;
          cmd.y1   = ya_m1;
        end
      end
      rdce_pkg::OP_RECT: begin
        if ((in_x_first > in_x_last) || (in_y_first > in_y_last)) begin
          cmd.status = rdce_pkg::ST_SIZE;
        end else if (!xa_ok || !xb_ok || !ya_ok || !yb_ok) begin
          cmd.status = rdce_pkg::ST_RANGE;
        end else begin
          cmd.kind = rdce_pkg::CMD_FILL;
          cmd.x0   = xa_m1;
          cmd.x1   = xb_m1;
          cmd.y0   = ya_m1;
          cmd.y1   = yb_m1;
        end
      end
      rdce_pkg::OP_RECOLOR: begin
        if (!xa_ok || !ya_ok) begin
          cmd.status = rdce_pkg::ST_RANGE;
        end else begin
          cmd.kind = rdce_pkg::CMD_RECOLOR;
          cmd.px   = xa_m1;
          cmd.py   = ya_m1;
          cmd.x1   = eff_w - 9'd1;
          cmd.y1   = eff_h - 9'd1;
        end
      end
      rdce_pkg::OP_READ: begin
        if (!xa_ok || !ya_ok) begin
          cmd.status = rdce_pkg::ST_RANGE;
        end else begin
          cmd.kind = rdce_pkg::CMD_READ;
          cmd.px   = xa_m1;
          cmd.py   = ya_m1;
        end
      end
      default: begin
        cmd.kind = rdce_pkg::CMD_NONE;
      end
    endcase
  end

endmodule

### hdl/rdce_back.sv
module rdce_back #(
  parameter int MAX_WIDTH  = 256,
  parameter int MAX_HEIGHT = 256
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cmd_empty,
  input  rdce_pkg::cmd_t    cmd_head,
  output logic              cmd_pop,
  input  logic              res_full,
  output logic              res_push,
  output rdce_pkg::result_t res,
  output logic              busy_init
);

  localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [7:0] mem [DEPTH];

  rdce_pkg::back_state_t state_r, state_nxt;
  rdce_pkg::cmd_t        cmd_r, cmd_nxt;
  logic [AW-1:0]         base_r, base_nxt;
  rdce_pkg::coord_t      xc_r, xc_nxt;
  rdce_pkg::coord_t      yc_r, yc_nxt;
  logic [7:0]            seed_r, seed_nxt;
  logic [7:0]            pix_r, pix_nxt;
  logic                  pv_r, pv_nxt;
  logic [AW-1:0]         pa_r, pa_nxt;
  logic [AW-1:0]         clr_r, clr_nxt;
  logic [7:0]            rdata_r;

  logic [AW-1:0]         cur_addr;
  logic [AW-1:0]         pt_addr;
  logic [AW-1:0]         ra;
  logic [AW-1:0]         wa;
  logic [7:0]            wd;
  logic                  we;
  rdce_pkg::coord_t      row_sel;
  logic                  row_end;
  logic                  box_end;

  assign cur_addr  = base_r + AW'(xc_r);
  assign pt_addr   = base_r + AW'(cmd_r.px);
  assign row_end   = (xc_r == cmd_r.x1);
  assign box_end   = row_end && (yc_r == cmd_r.y1);
  assign row_sel   = (cmd_r.kind == rdce_pkg::CMD_FILL) ? cmd_r.y0 : cmd_r.py;
  assign busy_init = (state_r == rdce_pkg::BK_INIT);
  assign res.status = cmd_r.status;
  assign res.pixel  = pix_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    rdata_r <= mem[ra];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= rdce_pkg::BK_INIT;
      clr_r   <= '0;
      pv_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      clr_r   <= clr_nxt;
      pv_r    <= pv_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r  <= cmd_nxt;
    base_r <= base_nxt;
    xc_r   <= xc_nxt;
    yc_r   <= yc_nxt;
    seed_r <= seed_nxt;
    pix_r  <= pix_nxt;
    pa_r   <= pa_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    cmd_nxt   = cmd_r;
    base_nxt  = base_r;
    xc_nxt    = xc_r;
    yc_nxt    = yc_r;
    seed_nxt  = seed_r;
    pix_nxt   = pix_r;
    pv_nxt    = 1'b0;
    pa_nxt    = pa_r;
    clr_nxt   = clr_r;
    we        = 1'b0;
    wa        = cur_addr;
    wd        = cmd_r.color;
    ra        = cur_addr;
    cmd_pop   = 1'b0;
    res_push  = 1'b0;

    case (state_r)
      rdce_pkg::BK_INIT: begin
        we      = 1'b1;
        wa      = clr_r;
        wd      = rdce_pkg::BLANK_COLOR;
        clr_nxt = clr_r + 1'b1;
        if (clr_r == AW'(DEPTH - 1)) begin
          state_nxt = rdce_pkg::BK_IDLE;
        end
      end
      rdce_pkg::BK_IDLE: begin
        if (!cmd_empty) begin
          cmd_pop = 1'b1;
          cmd_nxt = cmd_head;
          pix_nxt = '0;
          state_nxt = (cmd_head.kind == rdce_pkg::CMD_NONE) ?
                      rdce_pkg::BK_RESULT : rdce_pkg::BK_SETUP;
        end
      end
      rdce_pkg::BK_SETUP: begin
        base_nxt = AW'(32'(row_sel) * MAX_WIDTH);
        xc_nxt   = cmd_r.x0;
        yc_nxt   = cmd_r.y0;
        case (cmd_r.kind)
          rdce_pkg::CMD_FILL:    state_nxt = rdce_pkg::BK_FILL;
          rdce_pkg::CMD_RECOLOR: state_nxt = rdce_pkg::BK_SEED_RD;
          rdce_pkg::CMD_READ:    state_nxt = rdce_pkg::BK_READ_RD;
          default:               state_nxt = rdce_pkg::BK_RESULT;
        endcase
      end
      rdce_pkg::BK_FILL: begin
        we = 1'b1;
        if (box_end) begin
          state_nxt = rdce_pkg::BK_RESULT;
        end else if (row_end) begin
          xc_nxt   = cmd_r.x0;
          yc_nxt   = yc_r + 9'd1;
          base_nxt = base_r + AW'(MAX_WIDTH);
        end else begin
          xc_nxt = xc_r + 9'd1;
        end
      end
      rdce_pkg::BK_SEED_RD: begin
        ra        = pt_addr;
        base_nxt  = '0;
        state_nxt = rdce_pkg::BK_SEED_WAIT;
      end
      rdce_pkg::BK_SEED_WAIT: begin
        seed_nxt  = rdata_r;
        state_nxt = rdce_pkg::BK_SCAN;
      end
      rdce_pkg::BK_SCAN: begin
        // Read ahead one pixel; write back the previous one if it matched.
        pv_nxt = 1'b1;
        pa_nxt = cur_addr;
        if (pv_r && (rdata_r == seed_r)) begin
          we = 1'b1;
          wa = pa_r;
        end
        if (box_end) begin
          state_nxt = rdce_pkg::BK_DRAIN;
        end else if (row_end) begin
          xc_nxt   = cmd_r.x0;
          yc_nxt   = yc_r + 9'd1;
          base_nxt = base_r + AW'(MAX_WIDTH);
        end else begin
          xc_nxt = xc_r + 9'd1;
        end
      end
      rdce_pkg::BK_DRAIN: begin
        if (pv_r && (rdata_r == seed_r)) begin
          we = 1'b1;
          wa = pa_r;
        end
        state_nxt = rdce_pkg::BK_RESULT;
      end
      rdce_pkg::BK_READ_RD: begin
        ra        = pt_addr;
        state_nxt = rdce_pkg::BK_READ_WAIT;
      end
      rdce_pkg::BK_READ_WAIT: begin
        pix_nxt   = rdata_r;
        state_nxt = rdce_pkg::BK_RESULT;
      end
      rdce_pkg::BK_RESULT: begin
        if (!res_full) begin
          res_push  = 1'b1;
          state_nxt = rdce_pkg::BK_IDLE;
        end
      end
      default: begin
        state_nxt = rdce_pkg::BK_IDLE;
      end
    endcase
  end

endmodule
